// ----- hdl/prefix_code_bit_packer_defines.svh -----
// Assertion macros used by the checker file of the prefix-code bit packer.
// No dependencies; include by bare file name.
`ifndef PREFIX_CODE_BIT_PACKER_DEFINES_SVH
`define PREFIX_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PCBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PCBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PCBP_ASSERT_ALWAYS_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pcbp_pkg.sv -----
// Package of the prefix-code bit packer: widths, operation codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcbp_pkg;

    localparam int OP_W        = 2;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 32;
    localparam int BYTE_BITS   = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_CODE_LEN = 32;
    // stored length never exceeds the code field
    localparam int LEN_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int PEND_W      = BYTE_BITS - 1;
    localparam int PCNT_W      = 3;
    localparam int MAX_BYTES   = 4;
    localparam int BCNT_W      = 3;
    localparam int ACC_W       = CODE_W + PEND_W;
    localparam int ALIGN_W     = BYTE_BITS * (MAX_BYTES + 1);
    localparam int TOTAL_W     = 6;
    localparam int BUF_W       = BYTE_BITS * MAX_BYTES;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    // bytes left-aligned, first byte in the top eight bits
    typedef struct packed {
        logic [BUF_W-1:0]  bytes;
        logic [BCNT_W-1:0] count;
    } t_burst;

endpackage

`default_nettype wire

// ----- hdl/pcbp_in_if.sv -----
// Input channel of the prefix-code bit packer: valid/ready plus one input item.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pcbp_in_if
    import pcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;

    modport source (output valid, output operation, output symbol,
                    output code_length, output code_bits, input ready);
    modport sink   (input valid, input operation, input symbol,
                    input code_length, input code_bits, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcbp_out_if.sv -----
// Output channel of the prefix-code bit packer: valid/ready plus one packed byte.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pcbp_out_if
    import pcbp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data;
    logic                 last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/prefix_code_bit_packer.sv -----
// Top level of the prefix-code bit packer: code table, packing stage, byte output.
// Depends on pcbp_pkg, pcbp_in_if, pcbp_out_if and the three submodules.
`timescale 1ns / 1ps
`default_nettype none

// Prefix-code (Huffman style) bit packer. A load item writes one symbol's code
// length and code into a 256-entry table; lengths above 32 saturate and the
// code keeps only that many low bits. An encode item looks the symbol up and
// appends its code, first bit first, behind up to seven pending bits; every
// completed byte comes out MSB first, with last set on the final byte of that
// item. A flush item emits the pending bits left-aligned and zero-padded as one
// byte, then clears them. Symbols never loaded encode to nothing. The block
// takes one item per cycle while its output is not backed up: the registered
// table read and the packing register take the item together, and a byte
// register after them lets a new item enter while bytes still wait. The first
// byte is presented from that byte register once the packing stage's burst has
// moved into it. The one-byte output channel sets the pace: an item yields up
// to four bytes, one per handshake; items without bytes do not wait on it.
// The table's used/unused marks live in flip-flops cleared by reset, so no
// clearing pass follows reset.

module prefix_code_bit_packer
    import pcbp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcbp_in_if.sink    i_in,
    pcbp_out_if.source o_out
);

    logic   in_fire;
    logic   load_en;
    logic   pack_ready;
    logic   burst_valid;
    logic   burst_ready;
    t_entry rd_entry;
    t_burst burst;

    // accept whenever the packing stage frees up this cycle
    assign i_in.ready = pack_ready;
    assign in_fire    = i_in.valid && pack_ready;
    assign load_en    = in_fire && (i_in.operation == OP_LOAD);

    // write on load, read on every item so the entry lines up with it
    pcbp_code_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (load_en),
        .i_wr_addr   (i_in.symbol),
        .i_wr_length (i_in.code_length),
        .i_wr_code   (i_in.code_bits),
        .i_rd_en     (in_fire),
        .i_rd_addr   (i_in.symbol),
        .o_rd_entry  (rd_entry)
    );

    // merge the code with the pending bits, update them, form the burst
    pcbp_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_op          (i_in.operation),
        .i_entry       (rd_entry),
        .i_burst_ready (burst_ready),
        .o_ready       (pack_ready),
        .o_burst_valid (burst_valid),
        .o_burst       (burst)
    );

    // drain the burst one byte per handshake
    pcbp_byte_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .i_burst       (burst),
        .o_burst_ready (burst_ready),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

// ----- hdl/pcbp_code_table.sv -----
// Code table: 256-entry length and code memories with a registered read port.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcbp_code_table
    import pcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [SYM_W-1:0]  i_wr_addr,
    input  wire logic [LEN_W-1:0]  i_wr_length,
    input  wire logic [CODE_W-1:0] i_wr_code,
    input  wire logic              i_rd_en,
    input  wire logic [SYM_W-1:0]  i_rd_addr,
    output t_entry                 o_rd_entry
);

    logic [LEN_W-1:0]       r_len_mem  [TABLE_DEPTH];
    logic [CODE_W-1:0]      r_code_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_len_valid;
    logic [LEN_W-1:0]       r_rd_len;
    logic [CODE_W-1:0]      r_rd_code;
    logic                   r_rd_valid;
    logic [LEN_W-1:0]       wr_len;
    logic [CODE_W-1:0]      wr_mask;

    // saturate the length, keep only that many low code bits
    always_comb begin
        if (i_wr_length > LEN_W'(LEN_CAP)) begin
            wr_len = LEN_W'(LEN_CAP);
        end else begin
            wr_len = i_wr_length;
        end
        wr_mask = ~({CODE_W{1'b1}} << wr_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_len_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_len_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_len_mem[i_wr_addr]  <= wr_len;
            r_code_mem[i_wr_addr] <= i_wr_code & wr_mask;
        end
        if (i_rd_en) begin
            r_rd_len  <= r_len_mem[i_rd_addr];
            r_rd_code <= r_code_mem[i_rd_addr];
        end
    end

    // never-loaded entries read as unused
    assign o_rd_entry.len  = r_rd_valid ? r_rd_len : '0;
    assign o_rd_entry.code = r_rd_code;

endmodule

`default_nettype wire

// ----- hdl/pcbp_pack.sv -----
// Packing stage: appends a looked-up code to the pending bits and forms the byte burst.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcbp_pack
    import pcbp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [OP_W-1:0] i_op,
    input  t_entry               i_entry,
    input  wire logic            i_burst_ready,
    output logic                 o_ready,
    output logic                 o_burst_valid,
    output t_burst               o_burst
);

    logic              r_valid;
    logic [OP_W-1:0]   r_op;
    logic [PEND_W-1:0] r_pend_bits;
    logic [PCNT_W-1:0] r_pend_count;
    logic [PEND_W-1:0] n_pend_bits;
    logic [PCNT_W-1:0] n_pend_count;

    logic [ACC_W-1:0]   acc;
    logic [TOTAL_W-1:0] total;
    logic [BCNT_W-1:0]  count;
    logic [ALIGN_W-1:0] aligned;
    logic               advance;

    always_comb begin
        acc          = '0;
        total        = '0;
        count        = '0;
        n_pend_bits  = r_pend_bits;
        n_pend_count = r_pend_count;
        case (t_op'(r_op))
            OP_ENCODE: begin
                // an unused symbol appends nothing; its code is not looked at
                if (i_entry.len != '0) begin
                    acc   = (ACC_W'(r_pend_bits) << i_entry.len) | ACC_W'(i_entry.code);
                    total = TOTAL_W'(r_pend_count) + TOTAL_W'(i_entry.len);
                    count = total[TOTAL_W-1:3];
                    n_pend_bits  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
                    n_pend_count = total[2:0];
                end
            end
            OP_FLUSH: begin
                acc   = ACC_W'(r_pend_bits);
                total = TOTAL_W'(r_pend_count);
                count = (r_pend_count != '0) ? BCNT_W'(1) : '0;
                n_pend_bits  = '0;
                n_pend_count = '0;
            end
            default: begin
                count = '0;
            end
        endcase
        // move the earliest pending bit to the top of the window
        aligned = ALIGN_W'(acc) << (TOTAL_W'(ALIGN_W) - total);
    end

    assign advance        = r_valid && ((count == '0) || i_burst_ready);
    assign o_ready        = !r_valid || advance;
    assign o_burst_valid  = r_valid && (count != '0);
    assign o_burst.bytes  = aligned[ALIGN_W-1 -: BUF_W];
    assign o_burst.count  = count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_bits  <= '0;
            r_pend_count <= '0;
        end else begin
            if (i_fire) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (advance) begin
                r_pend_bits  <= n_pend_bits;
                r_pend_count <= n_pend_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_op <= i_op;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pcbp_byte_out.sv -----
// Output register: holds up to four bytes and hands them out one per cycle while ready.
// Depends on pcbp_pkg and pcbp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pcbp_byte_out
    import pcbp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_burst_valid,
    input  t_burst      i_burst,
    output logic        o_burst_ready,
    pcbp_out_if.source  o_out
);

    logic [BUF_W-1:0]  r_buf;
    logic [BCNT_W-1:0] r_count;
    logic              out_fire;
    logic              take;

    assign out_fire      = (r_count != '0) && o_out.ready;
    assign o_burst_ready = (r_count == '0) || ((r_count == BCNT_W'(1)) && o_out.ready);
    assign take          = i_burst_valid && o_burst_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (take) begin
            r_count <= i_burst.count;
        end else if (out_fire) begin
            r_count <= r_count - BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf <= i_burst.bytes;
        end else if (out_fire) begin
            r_buf <= r_buf << BYTE_BITS;
        end
    end

    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_buf[BUF_W-1 -: BYTE_BITS];
    assign o_out.last  = (r_count == BCNT_W'(1));

endmodule

`default_nettype wire

// ----- hdl/pcbp_checker.sv -----
// Port-level checks of the prefix-code bit packer, bound to its top level.
// Depends on pcbp_pkg and prefix_code_bit_packer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_code_bit_packer_defines.svh"

module pcbp_checker
    import pcbp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [BYTE_BITS-1:0] i_out_data,
    input wire logic                 i_out_last
);

    logic in_fire;

    assign in_fire = i_in_valid && i_in_ready;

    // a stalled byte holds
    `PCBP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_last), "output byte changed while stalled")

    // reset empties the output register
    `PCBP_ASSERT_ALWAYS_NXT(a_rst_quiet, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

    // input back-pressure only comes from a waiting byte
    `PCBP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid, "input stalled with output idle")

    // with in_fire low both now and in its $past value, an idle output stays idle
    `PCBP_ASSERT_NXT(a_idle_quiet, i_clk, i_rst_n, !i_out_valid && !in_fire && !$past(in_fire), !i_out_valid, "byte appeared without an item")

endmodule

bind prefix_code_bit_packer pcbp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_out_last  (o_out.last)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the prefix-code bit packer: directed table, then random traffic.
// Depends on pcbp_pkg, pcbp_in_if, pcbp_out_if and prefix_code_bit_packer.

module testbench;
    import pcbp_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 355;
    localparam int TABLE_LOADS  = 30;    // opening loads of the random part
    localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
    localparam int HOLD_AFTER   = 100;   // bytes taken before the hold-off starts
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_CAP    = 40;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    // One stimulus row; where typed is set, n and word give the bytes to expect
    // (first byte in the top eight bits of word).
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic              typed;
        logic [2:0]        n;
        logic [31:0]       word;
    } t_stim_row;

    typedef struct {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } t_packed_byte;

    localparam t_stim_row DIRECTED_ROWS [26] = '{
        // after reset: nothing loaded, nothing pending, reserved opcode ignored
        '{OP_ENCODE,   8'h41, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_FLUSH,    8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_RESERVED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0000_0000},
        // one whole byte, then a full 32-bit code
        '{OP_LOAD,     8'h00, 6'd8,  32'h0000_00A5, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd1, 32'hA500_0000},
        '{OP_LOAD,     8'hFF, 6'd32, 32'hDEAD_BEEF, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'hFF, 6'd0,  32'h0000_0000, 1'b1, 3'd4, 32'hDEAD_BEEF},
        // longest length field saturates to the code width
        '{OP_LOAD,     8'h01, 6'd63, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h01, 6'd0,  32'h0000_0000, 1'b1, 3'd4, 32'hFFFF_FFFF},
        // single-bit code: stays pending, flush pads it, second flush is empty
        '{OP_LOAD,     8'h02, 6'd1,  32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h02, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_FLUSH,    8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd1, 32'h8000_0000},
        '{OP_FLUSH,    8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        // codes that straddle byte borders
        '{OP_LOAD,     8'h03, 6'd3,  32'h0000_0005, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h03, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h03, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h03, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_LOAD,     8'h04, 6'd7,  32'hFFFF_FF7F, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h04, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h04, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        // seven pending bits plus a 32-bit code: the four-byte worst case
        '{OP_ENCODE,   8'hFF, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        '{OP_FLUSH,    8'h00, 6'd0,  32'h0000_0000, 1'b0, 3'd0, 32'h0000_0000},
        // zero length retires a symbol
        '{OP_LOAD,     8'h00, 6'd0,  32'h1234_5678, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h00, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_LOAD,     8'h80, 6'd40, 32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
        '{OP_ENCODE,   8'h80, 6'd0,  32'h0000_0000, 1'b1, 3'd4, 32'h0000_0000}
    };

    logic i_clk;
    logic i_rst_n;

    pcbp_in_if  in_ch ();
    pcbp_out_if out_ch ();

    prefix_code_bit_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow of the block: code table and the bit accumulator.
    logic [LEN_W-1:0]  len_shadow  [TABLE_DEPTH];
    logic [CODE_W-1:0] code_shadow [TABLE_DEPTH];
    logic [PEND_W-1:0] held_bits;
    logic [PCNT_W-1:0] held_count;

    t_packed_byte   bytes_due [$];      // bytes still owed by the block, oldest first
    t_stim_row      rows_offered [$];   // items on the way into the block
    logic [SYM_W-1:0] live_syms [$];    // symbols the stimulus has loaded

    int mismatches;
    int bytes_checked;
    int quiet_cycles;
    int burst_left;
    int load_count, encode_count, flush_count, reserved_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Apply one item to the shadow and return the bytes it should produce.
    task automatic pack_code_bits(input t_stim_row row, output logic [31:0] word,
                                  output int n);
        int width;
        int total;
        logic [63:0] acc;
        word = '0;
        n = 0;
        case (row.op)
            OP_LOAD: begin
                // saturate the length, keep only that many low code bits
                width = row.len;
                if (width > MAX_CODE_LEN) width = MAX_CODE_LEN;
                if (width > CODE_W) width = CODE_W;
                len_shadow[row.sym] = LEN_W'(width);
                code_shadow[row.sym] = (width >= CODE_W) ? row.code
                                     : row.code & ((32'd1 << width) - 32'd1);
            end
            OP_ENCODE: begin
                width = len_shadow[row.sym];
                if (width != 0) begin
                    acc = (64'(held_bits) << width) | 64'(code_shadow[row.sym]);
                    total = int'(held_count) + width;
                    while (total >= BYTE_BITS && n < MAX_BYTES) begin
                        total -= BYTE_BITS;
                        word[31-8*n -: 8] = 8'(acc >> total);
                        n++;
                    end
                    held_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    held_count = PCNT_W'(total);
                end
            end
            OP_FLUSH: begin
                if (held_count != 0) begin
                    word[31:24] = 8'({1'b0, held_bits} << (BYTE_BITS - held_count));
                    n = 1;
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;  // reserved opcode: no effect
        endcase
    endtask

    // Offer one item, hold it until taken, then pace the next one in bursts.
    task automatic offer_item(input t_stim_row row);
        int hits [$];
        int gap;
        if (row.op == OP_LOAD) begin
            hits = live_syms.find_first_index(s) with (s == row.sym);
            if (row.len != 0 && hits.size() == 0)
                live_syms = {live_syms, row.sym};
            else if (row.len == 0 && hits.size() != 0)
                live_syms.delete(hits[0]);
        end
        rows_offered = {rows_offered, row};
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= row.op;
        in_ch.symbol      <= row.sym;
        in_ch.code_length <= row.len;
        in_ch.code_bits   <= row.code;
        do @(posedge i_clk); while (!in_ch.ready);
        case (row.op)
            OP_LOAD:   load_count++;
            OP_ENCODE: encode_count++;
            OP_FLUSH:  flush_count++;
            default:   reserved_count++;
        endcase
        // inside a burst, keep valid high; between bursts, drop it for a while
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Random item, mostly well-formed: encodes of loaded symbols with some
    // reloads and flushes, plus unloaded symbols and reserved opcodes as noise.
    function automatic t_stim_row random_row(input int k);
        t_stim_row row;
        int pick;
        int len_pick;
        row = '0;
        row.sym = SYM_W'($urandom_range(0, 255));
        pick = (k < TABLE_LOADS) ? 0 : $urandom_range(0, 99);
        if (pick < 10) begin
            row.op = OP_LOAD;
            len_pick = $urandom_range(0, 99);
            if (len_pick < 8)       row.len = '0;
            else if (len_pick < 18) row.len = LEN_W'($urandom_range(32, 63));
            else if (len_pick < 30) row.len = LEN_W'($urandom_range(13, 31));
            else                    row.len = LEN_W'($urandom_range(1, 12));
            row.code = $urandom;
        end else if (pick < 85) begin
            row.op = OP_ENCODE;
            if (pick < 75 && live_syms.size() != 0)
                row.sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
            row.len  = LEN_W'($urandom_range(0, 63));
            row.code = $urandom;
        end else if (pick < 95) begin
            row.op = OP_FLUSH;
        end else begin
            row.op   = OP_RESERVED;
            row.len  = LEN_W'($urandom_range(0, 63));
            row.code = $urandom;
        end
        return row;
    endfunction

    // Check bytes leaving the block, then predict for items entering it.
    always @(posedge i_clk) begin : monitor
        t_packed_byte got;
        t_stim_row    row;
        logic [31:0]  word;
        int           n;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                bytes_checked++;
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing outstanding",
                                              out_ch.data));
                end else begin
                    got = bytes_due.pop_front();
                    if (out_ch.data !== got.data)
                        report_mismatch($sformatf("data %02h, want %02h",
                                                  out_ch.data, got.data));
                    if (out_ch.last !== got.last)
                        report_mismatch($sformatf("last %b on byte %02h, want %b",
                                                  out_ch.last, got.data, got.last));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                row.op   = in_ch.operation;
                row.sym  = in_ch.symbol;
                row.len  = in_ch.code_length;
                row.code = in_ch.code_bits;
                pack_code_bits(row, word, n);
                if (rows_offered.size() != 0) begin
                    row = rows_offered.pop_front();
                    // hand-typed rows override the shadow's answer
                    if (row.typed) begin
                        word = row.word;
                        n    = row.n;
                    end
                end
                for (int b = 0; b < n; b++)
                    bytes_due = {bytes_due, t_packed_byte'{word[31-8*b -: 8], b == n - 1}};
            end
        end
    end

    // Receiver: rotate through stall patterns; hold off once for a long stretch
    // so the block backs up and stalls its input.
    initial begin : receiver
        t_rx_mode mode;
        int mode_left;
        int phase;
        int taken;
        int hold_left;
        bit hold_done;
        mode = RX_STEADY;
        mode_left = 0;
        phase = 0;
        taken = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) taken++;
            if (!hold_done && taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_STEADY: out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= (phase % 4 == 0);
                    default:   out_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d bytes outstanding",
                     quiet_cycles, bytes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        mismatches = 0;
        bytes_checked = 0;
        burst_left = 0;
        load_count = 0;
        encode_count = 0;
        flush_count = 0;
        reserved_count = 0;
        held_bits = '0;
        held_count = '0;
        foreach (len_shadow[i]) begin
            len_shadow[i]  = '0;
            code_shadow[i] = '0;
        end
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_LOAD;
        in_ch.symbol      <= '0;
        in_ch.code_length <= '0;
        in_ch.code_bits   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r])
            offer_item(DIRECTED_ROWS[r]);
        for (int k = 0; k < RANDOM_ITEMS; k++)
            offer_item(random_row(k));
        in_ch.valid <= 1'b0;

        // drain: wait for every owed byte, then give stray bytes time to show
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items: %0d loads, %0d encodes, %0d flushes, %0d reserved opcodes",
                 load_count, encode_count, flush_count, reserved_count);
        $display("bytes checked: %0d, mismatches: %0d, receiver held off %0d cycles once",
                 bytes_checked, mismatches, HOLD_CYCLES);
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
